// ===== src/ltr_pkg.sv =====
// shared types and constants of the label episode tracker
// no dependencies

package ltr_pkg;

    localparam int DAY_BITS   = 20;
    localparam int CNT_BITS   = DAY_BITS + 1;
    localparam int ID_BITS    = 4;
    localparam int LABEL_BITS = 5;

    typedef logic [DAY_BITS-1:0] day_t;
    typedef logic [CNT_BITS-1:0] cnt_t;

    typedef struct packed {
        cnt_t days;
        cnt_t episodes;
        day_t first_day;
        day_t recent_day;
    } entry_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FLUSH,
        ST_REPORT
    } ltr_state_t;

    typedef struct packed {
        logic s_ready;
        logic rep_issue;
    } ltr_ctrl_t;

endpackage

// ===== src/label_episode_tracker_unit.sv =====
// label episode tracker: per-day class labels in, per-class episode report out
// depends on ltr_pkg, ltr_ram, ltr_update
//
// input channel s_*: one transfer per day carrying class_label and end_of_series.
// a negative label or one beyond the class slots only advances the day index.
// while running, an item is taken every cycle: the class table sits in a ram
// with registered read, an item reads its entry on the transfer cycle and writes
// it back the next cycle, with forwarding when back-to-back items hit one slot.
// an item with end_of_series is updated first, then the block stops taking
// items and walks all NUM_CLASSES slots, one record per slot on m_*,
// report_last on the final one; the walk reads the next slot only after the
// previous record is loaded into the output register. the day counter is
// cleared on the end_of_series transfer; after the walk the block clears the
// seen flags and takes items again. a report thus holds the input for the
// whole walk; a receiver stall holds the output register and the walk waits for it.
// cfg_*: writes episode_gap, taken every cycle.
// reset clears the seen flags, day counter, gap and all control state; the
// ram needs no clearing, an unseen slot reads as zero in the report.

module label_episode_tracker_unit
    import ltr_pkg::*;
#(
    parameter int NUM_CLASSES = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [DAY_BITS-1:0]   cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [LABEL_BITS-1:0] s_class_label,
    input  logic                  s_end_of_series,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ID_BITS-1:0]    m_class_id,
    output logic                  m_class_seen,
    output logic [CNT_BITS-1:0]   m_day_total,
    output logic [CNT_BITS-1:0]   m_episode_total,
    output logic [DAY_BITS-1:0]   m_first_day_index,
    output logic [DAY_BITS-1:0]   m_last_day_index,
    output logic                  m_report_last
);

    localparam int SLOT_W = $clog2(NUM_CLASSES);

    ltr_state_t state_reg, state_next;
    ltr_ctrl_t  ctrl;

    day_t gap_reg;
    day_t day_reg;

    logic [NUM_CLASSES-1:0] seen_reg;

    logic              v1_reg;
    logic [SLOT_W-1:0] slot1_reg;
    day_t              day1_reg;

    entry_t            byp_reg;
    logic [SLOT_W-1:0] byp_slot_reg;
    logic              byp_valid_reg;

    logic [SLOT_W-1:0] rep_idx_reg;
    logic              rd_pend_reg;
    logic [SLOT_W-1:0] rd_slot_reg;
    logic              rd_last_reg;

    logic   m_valid_reg;
    logic [ID_BITS-1:0] m_class_id_reg;
    logic   m_class_seen_reg;
    entry_t m_entry_reg;
    logic   m_report_last_reg;

    logic              s_xfer;
    logic              label_ok;
    logic [SLOT_W-1:0] in_slot;
    logic [SLOT_W-1:0] raddr;
    entry_t            ram_q;
    entry_t            old_entry;
    entry_t            new_entry;
    logic              rep_last_idx;
    logic              out_load;

    assign s_xfer   = s_valid && ctrl.s_ready;
    assign label_ok = !s_class_label[LABEL_BITS-1]
                      && (32'(s_class_label[LABEL_BITS-2:0]) < NUM_CLASSES);
    assign in_slot  = SLOT_W'(s_class_label[LABEL_BITS-2:0]);
    assign raddr    = (state_reg == ST_REPORT) ? rep_idx_reg : in_slot;
    assign rep_last_idx = rep_idx_reg == SLOT_W'(NUM_CLASSES - 1);
    assign out_load = rd_pend_reg;

    ltr_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (NUM_CLASSES)
    ) u_table (
        .aclk  (aclk),
        .we    (v1_reg),
        .waddr (slot1_reg),
        .wdata (new_entry),
        .raddr (raddr),
        .rdata (ram_q)
    );

    assign old_entry = (byp_valid_reg && (byp_slot_reg == slot1_reg)) ? byp_reg : ram_q;

    ltr_update u_update (
        .old_entry (old_entry),
        .seen      (seen_reg[slot1_reg]),
        .day       (day1_reg),
        .gap       (gap_reg),
        .new_entry (new_entry)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN: begin
                if (s_xfer && s_end_of_series) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                state_next = ST_REPORT;
            end
            ST_REPORT: begin
                if (rd_pend_reg && rd_last_reg) begin
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    // state outputs
    always_comb begin
        ctrl = '0;
        case (state_reg)
            ST_RUN: begin
                ctrl.s_ready = 1'b1;
            end
            ST_REPORT: begin
                ctrl.rep_issue = !rd_pend_reg && (!m_valid_reg || m_ready);
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RUN;
            gap_reg       <= '0;
            day_reg       <= '0;
            seen_reg      <= '0;
            v1_reg        <= 1'b0;
            byp_valid_reg <= 1'b0;
            rep_idx_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                gap_reg <= cfg_data;
            end
            if (s_xfer) begin
                if (s_end_of_series) begin
                    day_reg <= '0;
                end else if (day_reg != '1) begin
                    day_reg <= day_reg + day_t'(1);
                end
            end
            v1_reg        <= s_xfer && label_ok;
            byp_valid_reg <= v1_reg;
            if (v1_reg) begin
                seen_reg[slot1_reg] <= 1'b1;
            end
            // report walk
            rd_pend_reg <= ctrl.rep_issue;
            if (ctrl.rep_issue) begin
                rep_idx_reg <= rep_last_idx ? '0 : rep_idx_reg + SLOT_W'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
                if (rd_last_reg) begin
                    seen_reg <= '0;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        slot1_reg    <= in_slot;
        day1_reg     <= day_reg;
        byp_reg      <= new_entry;
        byp_slot_reg <= slot1_reg;
        if (ctrl.rep_issue) begin
            rd_slot_reg <= rep_idx_reg;
            rd_last_reg <= rep_last_idx;
        end
        if (out_load) begin
            m_class_id_reg    <= ID_BITS'(rd_slot_reg);
            m_class_seen_reg  <= seen_reg[rd_slot_reg];
            m_entry_reg       <= seen_reg[rd_slot_reg] ? ram_q : '0;
            m_report_last_reg <= rd_last_reg;
        end
    end

    assign cfg_ready         = 1'b1;
    assign s_ready           = ctrl.s_ready;
    assign m_valid           = m_valid_reg;
    assign m_class_id        = m_class_id_reg;
    assign m_class_seen      = m_class_seen_reg;
    assign m_day_total       = m_entry_reg.days;
    assign m_episode_total   = m_entry_reg.episodes;
    assign m_first_day_index = m_entry_reg.first_day;
    assign m_last_day_index  = m_entry_reg.recent_day;
    assign m_report_last     = m_report_last_reg;

endmodule

// ===== src/ltr_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module ltr_ram #(
    parameter int WIDTH = 82,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ltr_update.sv =====
// per-class entry update for one labeled day
// depends on ltr_pkg

module ltr_update
    import ltr_pkg::*;
(
    input  entry_t old_entry,
    input  logic   seen,
    input  day_t   day,
    input  day_t   gap,
    output entry_t new_entry
);

    day_t day_span;
    logic new_episode;

    always_comb begin
        day_span    = day - old_entry.recent_day;
        new_episode = day_span > gap;
        new_entry   = old_entry;
        if (!seen) begin
            new_entry.days      = cnt_t'(1);
            new_entry.episodes  = cnt_t'(1);
            new_entry.first_day = day;
        end else begin
            if (old_entry.days != '1) begin
                new_entry.days = old_entry.days + cnt_t'(1);
            end
            if (new_episode && (old_entry.episodes != '1)) begin
                new_entry.episodes = old_entry.episodes + cnt_t'(1);
            end
        end
        new_entry.recent_day = day;
    end

endmodule
